// ----- design/kmdc_pkg.sv -----
// shared types, constants and helper functions for the keypad matrix scanner
`timescale 1ns / 1ps
`default_nettype none

package kmdc_pkg;

	// matrix geometry
	localparam int ROWS     = 4;
	localparam int COLS     = 4;
	localparam int NKEYS    = ROWS * COLS;
	localparam int KEY_W    = $clog2(NKEYS);
	localparam int LINE_W   = 4;
	localparam int IDX_W    = 2;
	localparam int PERIOD_W = 8;

	localparam logic [PERIOD_W-1:0] SCAN_INTERVAL_RESET = PERIOD_W'(10);

	// scan stage to click stage
	typedef struct packed {
		logic             scanned;
		logic [NKEYS-1:0] pressed;
	} scan_t;

	// one result item
	typedef struct packed {
		logic             scanned;
		logic             key_pressed;
		logic             key_clicked;
		logic [NKEYS-1:0] pressed_mask;
	} result_t;

	// raw matrix sample: a key is down when its row and column lines are both low
	function automatic logic [NKEYS-1:0] sample_matrix(input logic [LINE_W-1:0] rows,
			input logic [LINE_W-1:0] cols);
		logic [NKEYS-1:0] s;
		s = '0;
		for (int i = 0; i < ROWS; i++) begin
			for (int j = 0; j < COLS; j++) begin
				s[i*COLS+j] = ~rows[i] & ~cols[j];
			end
		end
		return s;
	endfunction

	// true when the query addresses a key inside the matrix
	function automatic logic query_in_range(input logic [IDX_W-1:0] qr,
			input logic [IDX_W-1:0] qc);
		return (int'(qr) < ROWS) && (int'(qc) < COLS);
	endfunction

	// key bit position row*COLS+col
	function automatic logic [KEY_W-1:0] key_index(input logic [IDX_W-1:0] qr,
			input logic [IDX_W-1:0] qc);
		return KEY_W'(KEY_W'(qr) * KEY_W'(COLS) + KEY_W'(qc));
	endfunction

endpackage

`default_nettype wire

// ----- design/kmdc_scan.sv -----
// period counter, matrix sampling and two-sample debounce
`timescale 1ns / 1ps
`default_nettype none

module kmdc_scan (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            en,
	input  wire logic [kmdc_pkg::PERIOD_W-1:0]   scan_interval,
	input  wire logic [kmdc_pkg::LINE_W-1:0]     row_lines,
	input  wire logic [kmdc_pkg::LINE_W-1:0]     col_lines,
	output kmdc_pkg::scan_t                      scan
);
	import kmdc_pkg::*;

	logic [PERIOD_W-1:0] cnt_q;
	logic [NKEYS-1:0]    last_q;
	logic [NKEYS-1:0]    stable_q;

	logic [PERIOD_W-1:0] cnt_dec;
	logic                do_scan;
	logic [NKEYS-1:0]    cur;
	logic [NKEYS-1:0]    same;
	logic [NKEYS-1:0]    stable_next;

	// countdown, scan when it lands on zero
	always_comb begin
		cnt_dec     = (cnt_q != '0) ? cnt_q - PERIOD_W'(1) : cnt_q;
		do_scan     = (cnt_dec == '0);
		cur         = sample_matrix(row_lines, col_lines);
		same        = ~(cur ^ last_q);
		stable_next = do_scan ? ((stable_q & ~same) | (cur & same)) : stable_q;
	end

	assign scan.scanned = do_scan;
	assign scan.pressed = stable_next;

	// state update once per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= SCAN_INTERVAL_RESET;
			last_q   <= '0;
			stable_q <= '0;
		end else if (en) begin
			cnt_q    <= do_scan ? scan_interval : cnt_dec;
			stable_q <= stable_next;
			if (do_scan) begin
				last_q <= cur;
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/kmdc_click.sv -----
// per-key click tracker and key query
`timescale 1ns / 1ps
`default_nettype none

module kmdc_click (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire kmdc_pkg::scan_t              scan,
	input  wire logic [kmdc_pkg::IDX_W-1:0]   query_row,
	input  wire logic [kmdc_pkg::IDX_W-1:0]   query_col,
	input  wire logic                         consume_click,
	output kmdc_pkg::result_t                 result
);
	import kmdc_pkg::*;

	logic [NKEYS-1:0] armed_q;
	logic [NKEYS-1:0] pending_q;

	logic [NKEYS-1:0] pending_set;
	logic [NKEYS-1:0] pending_next;
	logic             q_ok;
	logic [KEY_W-1:0] k;

	// release after a press raises the flag, then query and optional clear
	always_comb begin
		pending_set  = pending_q | (armed_q & ~scan.pressed);
		q_ok         = query_in_range(query_row, query_col);
		k            = key_index(query_row, query_col);
		pending_next = pending_set;
		if (q_ok && consume_click) begin
			pending_next[k] = 1'b0;
		end
		result.scanned      = scan.scanned;
		result.key_pressed  = q_ok & scan.pressed[k];
		result.key_clicked  = q_ok & pending_set[k];
		result.pressed_mask = scan.pressed;
	end

	// tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q   <= '0;
			pending_q <= '0;
		end else if (en) begin
			armed_q   <= scan.pressed;
			pending_q <= pending_next;
		end
	end

endmodule

`default_nettype wire

// ----- design/key_matrix_debounce_click.sv -----
// keypad matrix scanner top: input register, scan/click logic, result register
// a transaction passes the input register and then the result register before its result is presented
// throughput: one transaction per cycle, limited only by out_stall
// all key state is updated as the transaction moves from the input register to the result register
// reset: period counter and scan interval load 10, all key masks clear, both registers empty
`timescale 1ns / 1ps
`default_nettype none

module key_matrix_debounce_click (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [kmdc_pkg::PERIOD_W-1:0]   cfg_wr_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [kmdc_pkg::LINE_W-1:0]     row_lines,
	input  wire logic [kmdc_pkg::LINE_W-1:0]     col_lines,
	input  wire logic [kmdc_pkg::IDX_W-1:0]      query_row,
	input  wire logic [kmdc_pkg::IDX_W-1:0]      query_col,
	input  wire logic                            consume_click,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 scanned,
	output logic                                 key_pressed,
	output logic                                 key_clicked,
	output logic [kmdc_pkg::NKEYS-1:0]           pressed_mask
);
	import kmdc_pkg::*;

	logic [PERIOD_W-1:0] scan_interval_q;

	logic                valid_s1;
	logic [LINE_W-1:0]   row_lines_s1;
	logic [LINE_W-1:0]   col_lines_s1;
	logic [IDX_W-1:0]    query_row_s1;
	logic [IDX_W-1:0]    query_col_s1;
	logic                consume_click_s1;

	logic                valid_s2;
	result_t             res_s2;

	logic                in_acc;
	logic                adv;
	scan_t               scan;
	result_t             result;

	// handshake control
	assign adv      = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall = valid_s1 & ~adv;
	assign in_acc   = in_valid & ~in_stall;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_interval_q <= SCAN_INTERVAL_RESET;
		end else if (cfg_wr_en) begin
			scan_interval_q <= cfg_wr_data;
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			row_lines_s1     <= row_lines;
			col_lines_s1     <= col_lines;
			query_row_s1     <= query_row;
			query_col_s1     <= query_col;
			consume_click_s1 <= consume_click;
		end
	end

	kmdc_scan u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (adv),
		.scan_interval (scan_interval_q),
		.row_lines     (row_lines_s1),
		.col_lines     (col_lines_s1),
		.scan          (scan)
	);

	kmdc_click u_click (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (adv),
		.scan          (scan),
		.query_row     (query_row_s1),
		.query_col     (query_col_s1),
		.consume_click (consume_click_s1),
		.result        (result)
	);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= result;
		end
	end

	assign out_valid    = valid_s2;
	assign scanned      = res_s2.scanned;
	assign key_pressed  = res_s2.key_pressed;
	assign key_clicked  = res_s2.key_clicked;
	assign pressed_mask = res_s2.pressed_mask;

	// input side stalls only while the input register holds a blocked transaction
	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("in_stall raised without a blocked input register");

	// a transaction leaving the input register always lands in the result register
	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("advanced transaction did not reach the result register");

	// result payload only changes when a new transaction is loaded
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !adv) |=> ($stable(pressed_mask) && $stable(key_clicked)))
		else $error("result register changed without a new transaction");

	// a query outside the matrix never reports a press or a click
	a_clicked_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !query_in_range(query_row_s1, query_col_s1)) |=>
			(!key_pressed && !key_clicked))
		else $error("out of range query reported a key");

endmodule

`default_nettype wire

// ----- verif/key_matrix_debounce_click_checker.sv -----
// checker for the keypad scanner: predicts each result and compares it with the block output
`timescale 1ns / 1ps
`default_nettype none

module key_matrix_debounce_click_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [kmdc_pkg::PERIOD_W-1:0]   cfg_wr_data,
	input  wire logic                            in_valid,
	input  wire logic                            in_stall,
	input  wire logic [kmdc_pkg::LINE_W-1:0]     row_lines,
	input  wire logic [kmdc_pkg::LINE_W-1:0]     col_lines,
	input  wire logic [kmdc_pkg::IDX_W-1:0]      query_row,
	input  wire logic [kmdc_pkg::IDX_W-1:0]      query_col,
	input  wire logic                            consume_click,
	input  wire logic                            out_valid,
	input  wire logic                            out_stall,
	input  wire logic                            scanned,
	input  wire logic                            key_pressed,
	input  wire logic                            key_clicked,
	input  wire logic [kmdc_pkg::NKEYS-1:0]      pressed_mask,
	output int                                   errors,
	output int                                   reports_due
);
	import kmdc_pkg::*;

	// predicted scanner state
	logic [PERIOD_W-1:0] scan_period;
	logic [PERIOD_W-1:0] scan_countdown;
	logic [NKEYS-1:0]    prev_sample;
	logic [NKEYS-1:0]    debounced_keys;
	logic [NKEYS-1:0]    armed_keys;
	logic [NKEYS-1:0]    click_flags;

	// key reports predicted but not yet seen at the output
	result_t key_reports[$];

	initial errors = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		errors++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_mismatch(what, got, want);
		end
	endtask

	// one scanner tick: countdown, optional scan with debounce, click tracking, query
	task automatic scan_tick(input logic [LINE_W-1:0] rl, input logic [LINE_W-1:0] cl,
			input logic [IDX_W-1:0] qr, input logic [IDX_W-1:0] qc, input logic take,
			output result_t rep);
		logic [NKEYS-1:0] now_keys;
		logic [NKEYS-1:0] agree;
		logic             row_low;
		int               k;
		rep = '0;
		if (scan_countdown != 0) begin
			scan_countdown = scan_countdown - 1'b1;
		end
		if (scan_countdown == 0) begin
			scan_countdown = scan_period;
			rep.scanned = 1'b1;
			now_keys = '0;
			for (int i = 0; i < ROWS; i++) begin
				// a row with no line bit reads low, so it counts as active
				row_low = (i < LINE_W) ? ~rl[i] : 1'b1;
				for (int j = 0; j < COLS; j++) begin
					now_keys[i*COLS+j] = row_low & ~cl[j];
				end
			end
			agree = ~(now_keys ^ prev_sample);
			debounced_keys = (debounced_keys & ~agree) | (now_keys & agree);
			prev_sample = now_keys;
		end
		// release after a debounced press raises the click flag
		click_flags = click_flags | (armed_keys & ~debounced_keys);
		armed_keys = debounced_keys;
		if (int'(qr) < ROWS && int'(qc) < COLS) begin
			k = int'(qr) * COLS + int'(qc);
			rep.key_pressed = debounced_keys[k];
			rep.key_clicked = click_flags[k];
			if (take) begin
				click_flags[k] = 1'b0;
			end
		end
		rep.pressed_mask = debounced_keys;
	endtask

	// track both channels and the register write
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			scan_period = SCAN_INTERVAL_RESET;
			scan_countdown = SCAN_INTERVAL_RESET;
			prev_sample = '0;
			debounced_keys = '0;
			armed_keys = '0;
			click_flags = '0;
			key_reports.delete();
			reports_due <= 0;
		end else begin
			if (cfg_wr_en) begin
				scan_period = cfg_wr_data;
			end
			if (out_valid && !out_stall) begin
				got = '{scanned, key_pressed, key_clicked, pressed_mask};
				if (key_reports.size() == 0) begin
					report_mismatch("unexpected transaction", 32'(got), 32'(0));
				end else begin
					want = key_reports.pop_front();
					check_field("scanned", 32'(got.scanned), 32'(want.scanned));
					check_field("key_pressed", 32'(got.key_pressed), 32'(want.key_pressed));
					check_field("key_clicked", 32'(got.key_clicked), 32'(want.key_clicked));
					check_field("pressed_mask", 32'(got.pressed_mask), 32'(want.pressed_mask));
				end
			end
			if (in_valid && !in_stall) begin
				scan_tick(row_lines, col_lines, query_row, query_col, consume_click, want);
				key_reports.push_back(want);
			end
			reports_due <= key_reports.size();
		end
	end

endmodule

`default_nettype wire

// ----- verif/tb_key_matrix_debounce_click.sv -----
// testbench top for the keypad scanner: stimulus, receiver stalls, watchdog and verdict
`timescale 1ns / 1ps
`default_nettype none

module tb_key_matrix_debounce_click;
	import kmdc_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_OFF_CYCLES = 80;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HALF,
		STALL_HEAVY
	} stall_mode_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [PERIOD_W-1:0] cfg_wr_data;
	logic                in_valid;
	logic                in_stall;
	logic [LINE_W-1:0]   row_lines;
	logic [LINE_W-1:0]   col_lines;
	logic [IDX_W-1:0]    query_row;
	logic [IDX_W-1:0]    query_col;
	logic                consume_click;
	logic                out_valid;
	logic                out_stall;
	logic                scanned;
	logic                key_pressed;
	logic                key_clicked;
	logic [NKEYS-1:0]    pressed_mask;

	int          mismatch_count;
	int          reports_due;
	int          idle_cycles = 0;
	int          burst_left = 0;
	bit          back_to_back = 1'b0;
	bit          hold_req = 1'b0;
	bit          hold_seen = 1'b0;
	int          hold_left = 0;
	int          mode_left = 0;
	stall_mode_t stall_mode = STALL_NONE;

	always #6ns clk = ~clk;

	key_matrix_debounce_click DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.row_lines    (row_lines),
		.col_lines    (col_lines),
		.query_row    (query_row),
		.query_col    (query_col),
		.consume_click(consume_click),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.scanned      (scanned),
		.key_pressed  (key_pressed),
		.key_clicked  (key_clicked),
		.pressed_mask (pressed_mask)
	);

	key_matrix_debounce_click_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.row_lines    (row_lines),
		.col_lines    (col_lines),
		.query_row    (query_row),
		.query_col    (query_col),
		.consume_click(consume_click),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.scanned      (scanned),
		.key_pressed  (key_pressed),
		.key_clicked  (key_clicked),
		.pressed_mask (pressed_mask),
		.errors       (mismatch_count),
		.reports_due  (reports_due)
	);

	// receiver: stall pattern that changes mode now and then, plus requested hold-offs
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					stall_mode = stall_mode_t'($urandom_range(3));
					mode_left = $urandom_range(20, 120);
				end
				mode_left--;
				case (stall_mode)
					STALL_NONE:  out_stall <= 1'b0;
					STALL_LIGHT: out_stall <= ($urandom_range(3) == 0);
					STALL_HALF:  out_stall <= $urandom_range(1);
					default:     out_stall <= ($urandom_range(9) != 0);
				endcase
			end
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired at %0t ns", $time);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// sender pacing: bursts of random length separated by random gaps, or back to back when requested
	task automatic pace_sender();
		int gap;
		if (back_to_back) begin
			gap = 0;
		end else if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// offer one tick and wait until it is taken
	task automatic send_tick(input logic [LINE_W-1:0] rl, input logic [LINE_W-1:0] cl,
			input logic [IDX_W-1:0] qr, input logic [IDX_W-1:0] qc, input logic take);
		in_valid <= 1'b1;
		row_lines <= rl;
		col_lines <= cl;
		query_row <= qr;
		query_col <= qc;
		consume_click <= take;
		do @(posedge clk); while (in_stall);
		pace_sender();
	endtask

	// stop offering and let every outstanding report come back
	task automatic drain_reports();
		in_valid <= 1'b0;
		@(posedge clk);
		while (reports_due != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_period(input logic [PERIOD_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// key press sessions held for a few scan periods, with bounce and noise mixed in
	task automatic random_ticks(input int count, input int period);
		logic [LINE_W-1:0] held_rows;
		logic [LINE_W-1:0] held_cols;
		logic [LINE_W-1:0] rl;
		logic [LINE_W-1:0] cl;
		logic [IDX_W-1:0]  key_r;
		logic [IDX_W-1:0]  key_c;
		logic [IDX_W-1:0]  qr;
		logic [IDX_W-1:0]  qc;
		int                held_for;
		held_rows = '1;
		held_cols = '1;
		key_r = '0;
		key_c = '0;
		held_for = 0;
		for (int n = 0; n < count; n++) begin
			if (held_for == 0) begin
				key_r = IDX_W'($urandom);
				key_c = IDX_W'($urandom);
				case ($urandom_range(9)) inside
					[0:3]: begin
						held_rows = ~(LINE_W'(1) << key_r);
						held_cols = ~(LINE_W'(1) << key_c);
					end
					[4:5]: begin
						held_rows = '1;
						held_cols = '1;
					end
					6: begin
						held_rows = ~(LINE_W'(1) << key_r);
						held_cols = '0;
					end
					default: begin
						held_rows = LINE_W'($urandom);
						held_cols = LINE_W'($urandom);
					end
				endcase
				held_for = $urandom_range(1, 6) * (period + 1) + $urandom_range(0, 3);
			end
			held_for--;
			rl = held_rows;
			cl = held_cols;
			// contact bounce on a single tick
			if ($urandom_range(9) == 0) begin
				rl = LINE_W'($urandom);
				cl = LINE_W'($urandom);
			end
			if ($urandom_range(2) != 0) begin
				qr = key_r;
				qc = key_c;
			end else begin
				qr = IDX_W'($urandom);
				qc = IDX_W'($urandom);
			end
			send_tick(rl, cl, qr, qc, $urandom_range(2) == 0);
		end
	endtask

	// long receiver hold-off while the sender keeps offering back to back
	task automatic pressure_burst();
		hold_req <= ~hold_req;
		back_to_back = 1'b1;
		random_ticks(30, 0);
		back_to_back = 1'b0;
	endtask

	// stimulus and verdict
	initial begin
		int period;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		in_valid <= 1'b0;
		row_lines <= '1;
		col_lines <= '1;
		query_row <= '0;
		query_col <= '0;
		consume_click <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset period, then period zero, which scans on every tick once the running countdown has run out
		send_tick(4'h0, 4'h0, 2'd0, 2'd0, 1'b0);
		send_tick(4'hF, 4'hF, 2'd3, 2'd3, 1'b1);
		send_tick(4'h0, 4'hF, 2'd3, 2'd0, 1'b0);
		send_tick(4'hF, 4'h0, 2'd0, 2'd3, 1'b1);
		drain_reports();
		write_period(8'd0);
		// all keys down twice, then released twice, while the countdown from the reset period still runs
		send_tick(4'h0, 4'h0, 2'd0, 2'd0, 1'b0);
		send_tick(4'h0, 4'h0, 2'd3, 2'd3, 1'b0);
		send_tick(4'h0, 4'h0, 2'd3, 2'd3, 1'b0);
		send_tick(4'hF, 4'hF, 2'd3, 2'd3, 1'b0);
		send_tick(4'hF, 4'hF, 2'd3, 2'd3, 1'b0);
		// consume requests on the released key
		send_tick(4'hF, 4'hF, 2'd3, 2'd3, 1'b1);
		send_tick(4'hF, 4'hF, 2'd3, 2'd3, 1'b1);
		send_tick(4'hF, 4'hF, 2'd0, 2'd3, 1'b1);
		send_tick(4'hF, 4'hF, 2'd3, 2'd0, 1'b1);
		// single key at row 2, column 1, with one bounce tick
		send_tick(4'b1011, 4'b1101, 2'd2, 2'd1, 1'b0);
		send_tick(4'b1011, 4'b1101, 2'd2, 2'd1, 1'b0);
		send_tick(4'h0, 4'h0, 2'd2, 2'd1, 1'b0);
		send_tick(4'b1011, 4'b1101, 2'd2, 2'd1, 1'b0);
		send_tick(4'hF, 4'hF, 2'd2, 2'd1, 1'b0);
		send_tick(4'hF, 4'hF, 2'd2, 2'd1, 1'b1);
		// whole row 0 down
		send_tick(4'b1110, 4'h0, 2'd0, 2'd2, 1'b0);
		send_tick(4'b1110, 4'h0, 2'd0, 2'd2, 1'b0);
		send_tick(4'hF, 4'hF, 2'd1, 2'd2, 1'b0);
		drain_reports();

		// random phases over several sample periods, extremes included
		pressure_burst();
		random_ticks(300, 0);
		drain_reports();
		write_period(8'd1);
		random_ticks(300, 1);
		drain_reports();
		write_period(8'd255);
		random_ticks(300, 255);
		drain_reports();
		write_period(8'd2);
		random_ticks(300, 2);
		drain_reports();
		period = $urandom_range(3, 7);
		write_period(PERIOD_W'(period));
		pressure_burst();
		random_ticks(250, period);
		drain_reports();
		period = $urandom_range(0, 15);
		write_period(PERIOD_W'(period));
		random_ticks(300, period);
		drain_reports();
		repeat (8) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

`default_nettype wire
